// ===== rtl/core/psra_pkg.sv =====
// Package: shared constants for the per-source rate alert table.
package psra_pkg;
   localparam int Entries = 64;
   localparam int IdxW = $clog2(Entries);
   localparam int CntW = $clog2(Entries + 1);
   localparam logic [2:0] CsrThreshold = 3'd0;
   localparam logic [2:0] CsrWindow    = 3'd1;
   localparam logic [2:0] CsrTokenMode = 3'd2;
   localparam logic [2:0] CsrRefill    = 3'd3;
   localparam logic [1:0] FamIpv4 = 2'd0;
   localparam logic [31:0] OneToken = 32'h0001_0000;
endpackage

// ===== rtl/core/per_source_rate_alert_table_core.sv =====
// Top level: per-source rate alert table with a sequential scan of slot memory.
// Busy stays high while one item goes through its steps: the scan (one read per slot
// through the single read port of the slot memory, the read latency and picking the slot),
// the read of the chosen slot, the refill multiply and the write back. The result strobe
// comes in the cycle after the write back, with busy already low, so a new item can be
// taken once the result strobe comes, but not while the last one is still in work.
// The result strobe lasts one cycle and the receiver cannot stall it. Used bits reset at
// once; a free slot starts from all-zero fields.
module per_source_rate_alert_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_family,
   input  logic [63:0] req_addr_high,
   input  logic [63:0] req_addr_low,
   input  logic [31:0] req_packet_time,
   output logic        rsp_valid,
   output logic        rsp_alert,
   output logic [31:0] rsp_packet_count,
   output logic [31:0] rsp_reported_start,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   typedef struct packed {
      logic [1:0]  fam;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [31:0] wstart;
      logic [31:0] count;
      logic        alerted;
      logic [31:0] tokens;
      logic [31:0] last;
   } slot_type;

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_RD, S_CALC, S_WR} state_type;

   state_type state_ff;
   logic [15:0] thr_ff, win_ff;
   logic tok_ff;
   logic [31:0] rate_ff;
   logic [psra_pkg::Entries-1:0] used_ff;
   slot_type mem [psra_pkg::Entries];
   slot_type rd_ff, wr_in;
   logic [psra_pkg::IdxW-1:0] raddr_in, waddr;
   logic [psra_pkg::CntW-1:0] cnt_ff;
   logic [psra_pkg::IdxW-1:0] chk_ff;
   logic chk_v_ff;
   logic [1:0] fam_ff;
   logic [63:0] hi_ff, lo_ff;
   logic [31:0] now_ff;
   logic found_ff, hfree_ff, hold_ff;
   logic [psra_pkg::IdxW-1:0] sel_ff, free_ff, old_ff;
   logic [31:0] oldt_ff;
   logic [63:0] prod_ff;
   logic we;
   logic match;
   logic [63:0] khi;
   logic [63:0] klo;

   // key compare of the slot just read
   assign khi = (fam_ff == psra_pkg::FamIpv4) ? {hi_ff[63:32], 32'd0} : hi_ff;
   assign klo = (fam_ff == psra_pkg::FamIpv4) ? 64'd0 : lo_ff;
   assign match = (rd_ff.fam == fam_ff) &&
      ((fam_ff == psra_pkg::FamIpv4) ? (rd_ff.hi[63:32] == hi_ff[63:32])
                                     : (rd_ff.hi == hi_ff && rd_ff.lo == lo_ff));
   assign busy = (state_ff != S_IDLE);

   // slot update
   logic [63:0] cap, tsum;
   logic [31:0] tok1, tok2, whole, cnt1;
   logic al1, al2, alert_c, newslot;
   always_comb begin
      newslot = !found_ff;
      cap = {32'd0, 16'd0, thr_ff} << 16;
      // a free slot holds no earlier state
      wr_in = (newslot && hfree_ff) ? '0 : rd_ff;
      wr_in.fam = fam_ff;
      wr_in.hi = khi;
      wr_in.lo = klo;
      alert_c = 1'b0;
      tsum = 64'd0;
      tok1 = 32'd0; tok2 = 32'd0; whole = 32'd0; cnt1 = 32'd0; al1 = 1'b0; al2 = 1'b0;
      if (tok_ff) begin
         tok1 = rd_ff.tokens;
         al1 = rd_ff.alerted;
         if (newslot) begin
            tok1 = cap[31:0];
            wr_in.last = now_ff;
            al1 = 1'b0;
         end else if (now_ff > rd_ff.last) begin
            tsum = {32'd0, rd_ff.tokens} + prod_ff;
            tok1 = (tsum > cap || tsum < prod_ff) ? cap[31:0] : tsum[31:0];
            wr_in.last = now_ff;
            if (tok1 >= psra_pkg::OneToken) al1 = 1'b0;
         end
         tok2 = tok1;
         al2 = al1;
         if (tok1 >= psra_pkg::OneToken) tok2 = tok1 - psra_pkg::OneToken;
         else if (!al1) begin
            al2 = 1'b1;
            alert_c = 1'b1;
         end
         wr_in.tokens = tok2;
         wr_in.alerted = al2;
         whole = {16'd0, tok2[31:16]};
         cnt1 = (whole > {16'd0, thr_ff}) ? 32'd0 : {16'd0, thr_ff} - whole;
      end else begin
         al1 = rd_ff.alerted;
         cnt1 = rd_ff.count;
         if (newslot || (now_ff - rd_ff.wstart) >= {16'd0, win_ff}) begin
            wr_in.wstart = now_ff;
            cnt1 = 32'd1;
            al1 = 1'b0;
         end else if (rd_ff.count != 32'hFFFF_FFFF) cnt1 = rd_ff.count + 32'd1;
         wr_in.count = cnt1;
         al2 = al1;
         if (!al1 && cnt1 > {16'd0, thr_ff}) begin
            al2 = 1'b1;
            alert_c = 1'b1;
         end
         wr_in.alerted = al2;
      end
   end

   // address mux for the single read port; the chosen slot is held through the multiply
   always_comb begin
      raddr_in = cnt_ff[psra_pkg::IdxW-1:0];
      if (state_ff == S_RD || state_ff == S_CALC) raddr_in = sel_ff;
   end
   assign we = (state_ff == S_WR);
   assign waddr = sel_ff;

   // slot memory
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wr_in;
      rd_ff <= mem[raddr_in];
   end

   // control, scan and result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         thr_ff <= '0; win_ff <= '0; tok_ff <= 1'b0; rate_ff <= '0;
         used_ff <= '0;
         rsp_valid <= 1'b0;
         chk_v_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         rsp_valid <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               psra_pkg::CsrThreshold: thr_ff <= csr_wdata[15:0];
               psra_pkg::CsrWindow:    win_ff <= csr_wdata[15:0];
               psra_pkg::CsrTokenMode: tok_ff <= csr_wdata[0];
               psra_pkg::CsrRefill:    rate_ff <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  fam_ff <= req_family; hi_ff <= req_addr_high; lo_ff <= req_addr_low;
                  now_ff <= req_packet_time;
                  found_ff <= 1'b0; hfree_ff <= 1'b0; hold_ff <= 1'b0;
                  cnt_ff <= '0; chk_v_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // one slot per cycle: address out, data checked the cycle after
               chk_ff <= cnt_ff[psra_pkg::IdxW-1:0];
               chk_v_ff <= (cnt_ff < psra_pkg::CntW'(psra_pkg::Entries));
               if (cnt_ff < psra_pkg::CntW'(psra_pkg::Entries)) cnt_ff <= cnt_ff + 1'b1;
               if (chk_v_ff && !found_ff) begin
                  if (used_ff[chk_ff]) begin
                     if (match) begin
                        found_ff <= 1'b1; sel_ff <= chk_ff;
                     end else if (!hold_ff || rd_ff.wstart < oldt_ff) begin
                        hold_ff <= 1'b1; oldt_ff <= rd_ff.wstart; old_ff <= chk_ff;
                     end
                  end else if (!hfree_ff) begin
                     hfree_ff <= 1'b1; free_ff <= chk_ff;
                  end
               end
               if (!chk_v_ff && cnt_ff == psra_pkg::CntW'(psra_pkg::Entries)) begin
                  if (!found_ff) sel_ff <= hfree_ff ? free_ff : old_ff;
                  state_ff <= S_RD;
               end
            end
            S_RD: state_ff <= S_CALC;
            S_CALC: begin
               prod_ff <= {32'd0, now_ff - rd_ff.last} * {32'd0, rate_ff};
               state_ff <= S_WR;
            end
            S_WR: begin
               used_ff[sel_ff] <= 1'b1;
               rsp_valid <= 1'b1;
               rsp_alert <= alert_c;
               rsp_packet_count <= cnt1;
               rsp_reported_start <= tok_ff ? wr_in.last : wr_in.wstart;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_rsp_after_wr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_WR)) else $error("result without write back");
   a_busy_on_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("item not taken");
   a_used_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> used_ff[sel_ff]) else $error("slot not marked used");
`endif
endmodule
